// ===== hdl/rlsw_pkg.sv =====
// Shared types and constants for the RGBW LED serial waveform unit.
package rlsw_pkg;

  localparam int unsigned LedCountDefault   = 8;
  localparam int unsigned BitsPerLedDefault = 32;

  localparam int unsigned KindW    = 2;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned ColourW  = 32;
  localparam int unsigned BitW     = 5;
  localparam int unsigned TickW    = 16;
  localparam int unsigned PulseW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MaxStore = 1 << IdxW;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam logic [PulseW-1:0] OneHighReset  = PulseW'(700 / 5);
  localparam logic [PulseW-1:0] OneLowReset   = PulseW'(800 / 5);
  localparam logic [PulseW-1:0] ZeroHighReset = PulseW'(350 / 5);
  localparam logic [PulseW-1:0] ZeroLowReset  = PulseW'(600 / 5);
  localparam logic [TickW-1:0]  GapReset      = TickW'(60000 / 5);

  typedef enum logic [KindW-1:0] {
    KIND_TICK   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_HIGH  = 3'd0,
    CFG_ONE_LOW   = 3'd1,
    CFG_ZERO_HIGH = 3'd2,
    CFG_ZERO_LOW  = 3'd3,
    CFG_GAP       = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_STOP,
    OP_NONE
  } op_e;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_HIGH,
    PH_LOW,
    PH_TRAIL,
    PH_HALT
  } phase_e;

  typedef struct packed {
    op_e                op;
    logic [IdxW-1:0]    led_index;
    logic [ColourW-1:0] colour;
    logic               down_n;
    logic               right_n;
  } item_t;

endpackage

// ===== hdl/rlsw_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface rlsw_item_if import rlsw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [IdxW-1:0]    led_index;
  logic [ColourW-1:0] colour_value;
  logic               down_pin_n;
  logic               right_pin_n;

  modport source (output valid, kind, led_index, colour_value, down_pin_n, right_pin_n,
                  input ready);
  modport sink (input valid, kind, led_index, colour_value, down_pin_n, right_pin_n,
                output ready);
endinterface

interface rlsw_result_if;
  logic valid;
  logic ready;
  logic data_line;
  logic down_pressed;
  logic right_pressed;
  logic frame_done;
  logic halted;

  modport source (output valid, data_line, down_pressed, right_pressed, frame_done, halted,
                  input ready);
  modport sink (input valid, data_line, down_pressed, right_pressed, frame_done, halted,
                output ready);
endinterface

interface rlsw_cfg_if import rlsw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/rlsw_front.sv =====
// Front end: accepts input transactions and classifies them into operations.
module rlsw_front import rlsw_pkg::*; #(
  parameter int unsigned LED_COUNT = LedCountDefault
) (
  rlsw_item_if.sink in_i,
  output logic      push_valid_o,
  input  logic      push_ready_i,
  output item_t     push_item_o
);

  op_e op;

  always_comb begin
    op = OP_NONE;
    unique case (kind_e'(in_i.kind))
      KIND_TICK:  op = OP_TICK;
      KIND_WRITE: op = (32'(in_i.led_index) < 32'(LED_COUNT)) ? OP_WRITE : OP_NONE;
      KIND_STOP:  op = OP_STOP;
      default:    op = OP_NONE;
    endcase
  end

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  assign push_item_o.op        = op;
  assign push_item_o.led_index = in_i.led_index;
  assign push_item_o.colour    = in_i.colour_value;
  assign push_item_o.down_n    = in_i.down_pin_n;
  assign push_item_o.right_n   = in_i.right_pin_n;

endmodule

// ===== hdl/rlsw_queue.sv =====
// Short queue of classified operations between front end and back end.
module rlsw_queue import rlsw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  output logic  push_ready_o,
  input  item_t push_item_i,
  output logic  pop_valid_o,
  input  logic  pop_i,
  output item_t pop_item_o
);

  item_t                entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 push, pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_item_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) count_q <= count_q + 1'b1;
      else if (pop && !push) count_q <= count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// ===== hdl/rlsw_back.sv =====
// Back end: waveform sequencer, colour store, frame latch, timing registers.
module rlsw_back import rlsw_pkg::*; #(
  parameter int unsigned LED_COUNT    = LedCountDefault,
  parameter int unsigned BITS_PER_LED = BitsPerLedDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  output logic          item_pop_o,
  input  item_t         item_i,
  rlsw_cfg_if.sink      cfg_i,
  rlsw_result_if.source out_o
);

  localparam int unsigned LedW       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned StoreDepth = (LED_COUNT < MaxStore) ? LED_COUNT : MaxStore;
  localparam int unsigned StoreW     = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam logic [BitW-1:0] TopBit  = BitW'(BITS_PER_LED - 1);
  localparam logic [LedW-1:0] LastLed = LedW'(LED_COUNT - 1);

  logic [PulseW-1:0]  one_high_q, one_low_q, zero_high_q, zero_low_q;
  logic [TickW-1:0]   gap_q;
  logic [ColourW-1:0] store_q [StoreDepth];
  logic [ColourW-1:0] latch_q [StoreDepth];

  phase_e           phase_q, phase_d;
  logic [LedW-1:0]  led_q, led_d;
  logic [BitW-1:0]  bit_q, bit_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic             stop_q, stop_d;
  logic [1:0]       flags_q, flags_d;

  logic             out_valid_q, line_q, done_q, halted_q;
  logic [1:0]       out_flags_q;

  logic             pop, store_we, latch_en, done, cur_bit, reached;
  logic [TickW-1:0] lim, lim_eff, tick_inc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q  <= OneHighReset;
      one_low_q   <= OneLowReset;
      zero_high_q <= ZeroHighReset;
      zero_low_q  <= ZeroLowReset;
      gap_q       <= GapReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ONE_HIGH:  one_high_q  <= cfg_i.data[PulseW-1:0];
        CFG_ONE_LOW:   one_low_q   <= cfg_i.data[PulseW-1:0];
        CFG_ZERO_HIGH: zero_high_q <= cfg_i.data[PulseW-1:0];
        CFG_ZERO_LOW:  zero_low_q  <= cfg_i.data[PulseW-1:0];
        CFG_GAP:       gap_q       <= cfg_i.data[TickW-1:0];
        default: ;
      endcase
    end
  end

  assign cur_bit = (32'(led_q) < 32'(StoreDepth)) ? latch_q[led_q[StoreW-1:0]][bit_q] : 1'b0;

  always_comb begin
    unique case (phase_q)
      PH_HIGH: lim = TickW'(cur_bit ? one_high_q : zero_high_q);
      PH_LOW:  lim = TickW'(cur_bit ? one_low_q : zero_low_q);
      default: lim = gap_q;
    endcase
  end

  assign lim_eff  = (lim == '0) ? TickW'(1) : lim;
  assign tick_inc = tick_q + 1'b1;
  assign reached  = (tick_inc >= lim_eff);
  assign pop      = item_valid_i && (!out_valid_q || out_o.ready);
  assign item_pop_o = pop;

  always_comb begin
    phase_d  = phase_q;
    led_d    = led_q;
    bit_d    = bit_q;
    tick_d   = tick_q;
    stop_d   = stop_q;
    flags_d  = flags_q;
    done     = 1'b0;
    store_we = 1'b0;
    latch_en = 1'b0;
    if (pop) begin
      unique case (item_i.op)
        OP_WRITE: store_we = 1'b1;
        OP_STOP:  stop_d = 1'b1;
        OP_NONE:  ;
        OP_TICK: begin
          unique case (phase_q)
            PH_LEAD: begin
              if (tick_q == '0 && stop_q) begin
                phase_d = PH_HALT;
              end else if (reached) begin
                latch_en = 1'b1;
                phase_d  = PH_HIGH;
                tick_d   = '0;
                led_d    = '0;
                bit_d    = TopBit;
              end else begin
                tick_d = tick_inc;
              end
            end
            PH_HIGH: begin
              if (reached) begin
                phase_d = PH_LOW;
                tick_d  = '0;
              end else begin
                tick_d = tick_inc;
              end
            end
            PH_LOW: begin
              if (reached) begin
                tick_d = '0;
                if (bit_q == '0) begin
                  if (led_q == LastLed) begin
                    phase_d = PH_TRAIL;
                  end else begin
                    led_d   = led_q + 1'b1;
                    bit_d   = TopBit;
                    phase_d = PH_HIGH;
                  end
                end else begin
                  bit_d   = bit_q - 1'b1;
                  phase_d = PH_HIGH;
                end
              end else begin
                tick_d = tick_inc;
              end
            end
            PH_TRAIL: begin
              if (reached) begin
                flags_d = {!item_i.right_n, !item_i.down_n};
                done    = 1'b1;
                phase_d = PH_LEAD;
                tick_d  = '0;
              end else begin
                tick_d = tick_inc;
              end
            end
            PH_HALT: ;
            default: phase_d = PH_HALT;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      led_q   <= '0;
      bit_q   <= TopBit;
      tick_q  <= '0;
      stop_q  <= 1'b0;
      flags_q <= '0;
    end else begin
      phase_q <= phase_d;
      led_q   <= led_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      stop_q  <= stop_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) store_q[i] <= '0;
    end else if (store_we) begin
      store_q[StoreW'(item_i.led_index)] <= item_i.colour;
    end
  end

  always_ff @(posedge clk_i) begin
    if (latch_en) begin
      for (int i = 0; i < StoreDepth; i++) latch_q[i] <= store_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      line_q      <= (phase_q == PH_HIGH);
      out_flags_q <= flags_d;
      done_q      <= done;
      halted_q    <= (phase_d == PH_HALT);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.data_line     = line_q;
  assign out_o.down_pressed  = out_flags_q[0];
  assign out_o.right_pressed = out_flags_q[1];
  assign out_o.frame_done    = done_q;
  assign out_o.halted        = halted_q;

endmodule

// ===== hdl/rgbw_led_serial_waveform_unit.sv =====
// Top level of the RGBW LED serial waveform unit.
// A transaction passes through the queue entry and then the output register to the result.
// Throughput: 1 transaction per cycle, retired by the sequencer unless the result side stalls.
// A 2-entry queue parts the front end from the back end; output is registered.
// Reset: asynchronous, active low; colour store cleared, timing registers to defaults,
// sequencer in the leading gap.
module rgbw_led_serial_waveform_unit import rlsw_pkg::*; #(
  parameter int unsigned LED_COUNT    = LedCountDefault,
  parameter int unsigned BITS_PER_LED = BitsPerLedDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rlsw_item_if.sink     in_i,
  rlsw_cfg_if.sink      cfg_i,
  rlsw_result_if.source out_o
);

  logic  push_valid, push_ready, q_valid, q_pop;
  item_t push_item, q_item;

  rlsw_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  rlsw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_item_o   (q_item)
  );

  rlsw_back #(
    .LED_COUNT   (LED_COUNT),
    .BITS_PER_LED(BITS_PER_LED)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_pop_o   (q_pop),
    .item_i       (q_item),
    .cfg_i        (cfg_i),
    .out_o        (out_o)
  );

endmodule

// ===== hdl/rlsw_checker.sv =====
// Port-level checker for the RGBW LED serial waveform unit, with its bind.
module rlsw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_data_line_i,
  input logic out_down_pressed_i,
  input logic out_right_pressed_i,
  input logic out_frame_done_i,
  input logic out_halted_i
);

  logic seen_halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (out_valid_i && out_ready_i && out_halted_i) begin
      seen_halt_q <= 1'b1;
    end
  end

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && seen_halt_q |-> out_halted_i)
    else $error("halted dropped after a stop took effect");

  a_halt_line_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_halted_i |-> !out_data_line_i)
    else $error("data line high while halted");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_frame_done_i |-> !out_data_line_i && !out_halted_i)
    else $error("frame end with line high or halted");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable({out_data_line_i,
      out_down_pressed_i, out_right_pressed_i, out_frame_done_i, out_halted_i}))
    else $error("stalled result changed");

endmodule

bind rgbw_led_serial_waveform_unit rlsw_checker u_rlsw_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_data_line_i     (out_o.data_line),
  .out_down_pressed_i  (out_o.down_pressed),
  .out_right_pressed_i (out_o.right_pressed),
  .out_frame_done_i    (out_o.frame_done),
  .out_halted_i        (out_o.halted)
);

// ===== bench/rgbw_led_serial_waveform_unit_tb.sv =====
// Self-checking bench for the RGBW LED serial waveform unit: table, random and stop transactions.
`timescale 1ns / 100ps

module rgbw_led_serial_waveform_unit_tb;
  import rlsw_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;

  typedef struct packed {
    logic data_line;
    logic down_pressed;
    logic right_pressed;
    logic frame_done;
    logic halted;
  } line_status_t;

  typedef struct packed {
    kind_e              kind;
    logic [IdxW-1:0]    led_index;
    logic [ColourW-1:0] colour;
    logic               down_n;
    logic               right_n;
    logic               typed;
    line_status_t       want;
  } drive_row_t;

  typedef struct packed {
    logic [CfgDataW-1:0] one_hi;
    logic [CfgDataW-1:0] one_lo;
    logic [CfgDataW-1:0] zero_hi;
    logic [CfgDataW-1:0] zero_lo;
    logic [CfgDataW-1:0] gap;
  } timing_t;

  localparam drive_row_t IntroRows [16] = '{
    '{KIND_TICK,   3'd0, 32'h0000_0000, 1'b1, 1'b1, 1'b1, '0},
    '{KIND_WRITE,  3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, '0},
    '{KIND_WRITE,  3'd7, 32'h0000_0000, 1'b1, 1'b0, 1'b1, '0},
    '{KIND_UNUSED, 3'd7, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, '0},
    '{KIND_TICK,   3'd7, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, '0},
    '{KIND_TICK,   3'd0, 32'h0000_0000, 1'b0, 1'b1, 1'b1, '0},
    '{KIND_TICK,   3'd0, 32'h0000_0000, 1'b1, 1'b0, 1'b1, '0},
    '{KIND_WRITE,  3'd1, 32'h8000_0001, 1'b1, 1'b1, 1'b1, '0},
    '{KIND_WRITE,  3'd2, 32'h00FF_00FF, 1'b1, 1'b1, 1'b0, '0},
    '{KIND_WRITE,  3'd3, 32'h1234_5678, 1'b0, 1'b1, 1'b0, '0},
    '{KIND_WRITE,  3'd4, 32'h5555_5555, 1'b1, 1'b0, 1'b0, '0},
    '{KIND_WRITE,  3'd5, 32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, '0},
    '{KIND_WRITE,  3'd6, 32'hFFFF_0000, 1'b1, 1'b1, 1'b0, '0},
    '{KIND_WRITE,  3'd7, 32'h0F0F_0F0F, 1'b1, 1'b1, 1'b0, '0},
    '{KIND_UNUSED, 3'd0, 32'h0000_0000, 1'b1, 1'b1, 1'b0, '0},
    '{KIND_TICK,   3'd3, 32'h0000_0000, 1'b1, 1'b1, 1'b0, '0}
  };

  localparam timing_t SetMin   = '{16'd1, 16'd1, 16'd1, 16'd1, 16'd1};
  localparam timing_t SetZero  = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
  localparam timing_t SetMixed = '{16'hFF03, 16'd2, 16'h0101, 16'd4, 16'd5};
  localparam timing_t SetLongGap = '{16'd2, 16'd1, 16'd1, 16'd2, 16'hFFFF};
  localparam timing_t SetMaxPulse = '{16'd255, 16'd255, 16'd255, 16'd255, 16'd2};
  localparam timing_t SetStop  = '{16'd1, 16'd2, 16'd2, 16'd1, 16'd8};

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int unsigned cycles;
  int unsigned failed;

  rlsw_item_if   item_bus ();
  rlsw_cfg_if    cfg_bus ();
  rlsw_result_if status_bus ();

  rgbw_led_serial_waveform_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (item_bus),
    .cfg_i (cfg_bus),
    .out_o (status_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Waveform predictor state
  logic [ColourW-1:0] colour_mem [MaxStore];
  logic [ColourW-1:0] shown_mem [MaxStore];
  phase_e             seq_phase;
  logic [IdxW-1:0]    led_pos;
  logic [BitW-1:0]    bit_pos;
  logic [TickW-1:0]   tick_cnt;
  logic               stop_req;
  logic [1:0]         pressed;
  logic [PulseW-1:0]  one_hi, one_lo, zero_hi, zero_lo;
  logic [TickW-1:0]   gap_len;
  int unsigned        frames_seen;

  line_status_t status_q [$];
  logic         row_typed;
  line_status_t row_want;

  function automatic bit tick_over(logic [TickW-1:0] span);
    tick_cnt = tick_cnt + 1'b1;
    return tick_cnt >= ((span == '0) ? TickW'(1) : span);
  endfunction

  function automatic logic cur_bit();
    return shown_mem[led_pos][bit_pos];
  endfunction

  function automatic line_status_t step_waveform(kind_e k, logic [IdxW-1:0] idx,
                                                 logic [ColourW-1:0] val, logic dn, logic rn);
    line_status_t r;
    r = '0;
    case (k)
      KIND_WRITE: begin
        if (int'(idx) < LedCountDefault) colour_mem[idx] = val;
        r.data_line = (seq_phase == PH_HIGH);
      end
      KIND_STOP: begin
        stop_req = 1'b1;
        r.data_line = (seq_phase == PH_HIGH);
      end
      KIND_UNUSED: r.data_line = (seq_phase == PH_HIGH);
      default: begin
        case (seq_phase)
          PH_LEAD: begin
            if (tick_cnt == '0 && stop_req) begin
              seq_phase = PH_HALT;
            end else if (tick_over(gap_len)) begin
              shown_mem = colour_mem;
              seq_phase = PH_HIGH;
              tick_cnt  = '0;
              led_pos   = '0;
              bit_pos   = BitW'(BitsPerLedDefault - 1);
            end
          end
          PH_HIGH: begin
            r.data_line = 1'b1;
            if (tick_over(cur_bit() ? one_hi : zero_hi)) begin
              seq_phase = PH_LOW;
              tick_cnt  = '0;
            end
          end
          PH_LOW: begin
            if (tick_over(cur_bit() ? one_lo : zero_lo)) begin
              tick_cnt = '0;
              if (bit_pos == '0) begin
                if (int'(led_pos) + 1 >= LedCountDefault) begin
                  seq_phase = PH_TRAIL;
                end else begin
                  led_pos   = led_pos + 1'b1;
                  bit_pos   = BitW'(BitsPerLedDefault - 1);
                  seq_phase = PH_HIGH;
                end
              end else begin
                bit_pos   = bit_pos - 1'b1;
                seq_phase = PH_HIGH;
              end
            end
          end
          PH_TRAIL: begin
            if (tick_over(gap_len)) begin
              pressed      = {~rn, ~dn};
              r.frame_done = 1'b1;
              frames_seen++;
              seq_phase    = PH_LEAD;
              tick_cnt     = '0;
            end
          end
          default: seq_phase = PH_HALT;
        endcase
      end
    endcase
    r.down_pressed  = pressed[0];
    r.right_pressed = pressed[1];
    r.halted        = (seq_phase == PH_HALT);
    return r;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      failed++;
    end
  endfunction

  always @(posedge clk) begin : track
    line_status_t want;
    line_status_t got;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_idx_e'(cfg_bus.index))
          CFG_ONE_HIGH:  one_hi  = cfg_bus.data[PulseW-1:0];
          CFG_ONE_LOW:   one_lo  = cfg_bus.data[PulseW-1:0];
          CFG_ZERO_HIGH: zero_hi = cfg_bus.data[PulseW-1:0];
          CFG_ZERO_LOW:  zero_lo = cfg_bus.data[PulseW-1:0];
          CFG_GAP:       gap_len = cfg_bus.data;
          default: ;
        endcase
      end
      if (item_bus.valid && item_bus.ready) begin
        want = step_waveform(kind_e'(item_bus.kind), item_bus.led_index,
                             item_bus.colour_value, item_bus.down_pin_n, item_bus.right_pin_n);
        if (row_typed) want = row_want;
        status_q.push_back(want);
      end
      if (status_bus.valid && status_bus.ready) begin
        got.data_line     = status_bus.data_line;
        got.down_pressed  = status_bus.down_pressed;
        got.right_pressed = status_bus.right_pressed;
        got.frame_done    = status_bus.frame_done;
        got.halted        = status_bus.halted;
        if (status_q.size() == 0) begin
          $error("result transaction with none pending");
          failed++;
        end else begin
          want = status_q.pop_front();
          check_field("data_line", want.data_line, got.data_line);
          check_field("down_pressed", want.down_pressed, got.down_pressed);
          check_field("right_pressed", want.right_pressed, got.right_pressed);
          check_field("frame_done", want.frame_done, got.frame_done);
          check_field("halted", want.halted, got.halted);
        end
      end
    end
  end

  always @(negedge clk) begin
    status_bus.ready = steady || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_row(drive_row_t row);
    while (!steady && $urandom_range(99) < 34) begin
      item_bus.valid = 1'b0;
      @(negedge clk);
    end
    item_bus.valid        = 1'b1;
    item_bus.kind         = row.kind;
    item_bus.led_index    = row.led_index;
    item_bus.colour_value = row.colour;
    item_bus.down_pin_n   = row.down_n;
    item_bus.right_pin_n  = row.right_n;
    row_typed             = row.typed;
    row_want              = row.want;
    do @(posedge clk); while (!item_bus.ready);
    @(negedge clk);
    item_bus.valid = 1'b0;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic drain();
    while (status_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_settings(timing_t t);
    drain();
    write_reg(CFG_ONE_HIGH, t.one_hi);
    write_reg(CFG_ONE_LOW, t.one_lo);
    write_reg(CFG_ZERO_HIGH, t.zero_hi);
    write_reg(CFG_ZERO_LOW, t.zero_lo);
    write_reg(CFG_GAP, t.gap);
  endtask

  function automatic drive_row_t random_row(bit with_stop);
    drive_row_t row;
    int unsigned pick;
    row = '0;
    pick = $urandom_range(99);
    if (with_stop) row.kind = kind_e'($urandom_range(3));
    else if (pick < 84) row.kind = KIND_TICK;
    else if (pick < 96) row.kind = KIND_WRITE;
    else row.kind = KIND_UNUSED;
    row.led_index = IdxW'($urandom_range(MaxStore - 1));
    case ($urandom_range(7))
      0: row.colour = '0;
      1: row.colour = '1;
      default: row.colour = $urandom;
    endcase
    row.down_n  = 1'($urandom_range(1));
    row.right_n = 1'($urandom_range(1));
    return row;
  endfunction

  task automatic run_random(int unsigned frames, int unsigned items, bit through_lead);
    int unsigned goal;
    int unsigned n;
    goal = frames_seen + frames;
    n = 0;
    while (frames_seen < goal || n < items || (through_lead && seq_phase == PH_LEAD)) begin
      send_row(random_row(1'b0));
      n++;
      // hold the sender until the block has answered everything
      if (n % 64 == 0) drain();
    end
  endtask

  initial begin
    drive_row_t row;
    rst_n                 = 1'b0;
    steady                = 1'b0;
    failed                = 0;
    cycles                = 0;
    item_bus.valid        = 1'b0;
    item_bus.kind         = KIND_TICK;
    item_bus.led_index    = '0;
    item_bus.colour_value = '0;
    item_bus.down_pin_n   = 1'b1;
    item_bus.right_pin_n  = 1'b1;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_ONE_HIGH;
    cfg_bus.data          = '0;
    status_bus.ready      = 1'b0;
    row_typed             = 1'b0;
    row_want              = '0;
    foreach (colour_mem[i]) begin
      colour_mem[i] = '0;
      shown_mem[i]  = '0;
    end
    seq_phase   = PH_LEAD;
    led_pos     = '0;
    bit_pos     = BitW'(BitsPerLedDefault - 1);
    tick_cnt    = '0;
    stop_req    = 1'b0;
    pressed     = '0;
    one_hi      = OneHighReset;
    one_lo      = OneLowReset;
    zero_hi     = ZeroHighReset;
    zero_lo     = ZeroLowReset;
    gap_len     = GapReset;
    frames_seen = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (IntroRows[i]) send_row(IntroRows[i]);

    write_settings(SetMin);
    run_random(0, 150, 1'b0);
    write_settings(SetZero);
    run_random(0, 150, 1'b0);
    write_settings(SetMixed);
    run_random(0, 150, 1'b0);

    steady = 1'b1;
    write_settings(SetLongGap);
    run_random(0, 150, 1'b0);
    steady = 1'b0;

    write_settings(SetMaxPulse);
    run_random(0, 150, 1'b0);

    // land a stop inside the leading gap; it takes hold one frame later
    write_settings(SetStop);
    while (!(seq_phase == PH_LEAD && tick_cnt == TickW'(5))) begin
      row = random_row(1'b0);
      row.kind = KIND_TICK;
      send_row(row);
    end
    row = random_row(1'b0);
    row.kind = KIND_STOP;
    send_row(row);
    while (seq_phase != PH_HALT) begin
      row = random_row(1'b0);
      row.kind = KIND_TICK;
      send_row(row);
    end
    repeat (16) send_row(random_row(1'b1));

    drain();
    repeat (10) @(negedge clk);
    if (failed == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
